// ===== rtl/core/cbm_pkg.sv =====
// Shared types, constants and helpers for the serial-load bank mapper core.
// No dependencies; used by cbm_xlate and cartridge_bank_mapper_serial_load_core.
package cbm_pkg;

    localparam int MAX_PRG_BANKS = 32;

    localparam int OP_W     = 2;
    localparam int ADDR_W   = 16;
    localparam int VALUE_W  = 8;
    localparam int CYCLE_W  = 32;
    localparam int OFFSET_W = 19;
    localparam int MIRROR_W = 2;
    localparam int SEL_W    = 5;
    localparam int PMODE_W  = 2;
    localparam int SHIFT_W  = 6;

    localparam int PRG_CNT_W = 6;
    localparam int CHR_CNT_W = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 6;

    localparam int S_TDATA_W = 64;  // 58 payload bits padded to bytes
    localparam int M_TDATA_W = 24;  // 22 payload bits padded to bytes

    localparam logic [SHIFT_W-1:0]   SHIFT_INIT   = 6'b100000;
    localparam logic [PMODE_W-1:0]   PMODE_FIX_HI = 2'd3;
    localparam logic [PMODE_W-1:0]   PMODE_SWAP   = 2'd2;
    localparam logic [PRG_CNT_W-1:0] PRG_CNT_RST  = 6'd2;
    localparam logic [CHR_CNT_W-1:0] CHR_CNT_RST  = 5'd1;

    typedef enum logic [OP_W-1:0] {
        OP_PRG_READ  = 2'd0,
        OP_CHR_READ  = 2'd1,
        OP_REG_WRITE = 2'd2,
        OP_NONE      = 2'd3
    } op_t;

    // Target register of a serial load, address bits 15..13
    typedef enum logic [2:0] {
        TGT_CONTROL = 3'b100,
        TGT_CHR0    = 3'b101,
        TGT_CHR1    = 3'b110,
        TGT_PRG     = 3'b111
    } tgt_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRG_COUNT = 2'd0,
        CFG_CHR_COUNT = 2'd1,
        CFG_CHR_RAM   = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [PRG_CNT_W-1:0] prg_count;
        logic [CHR_CNT_W-1:0] chr_count;
        logic                 chr_is_ram;
    } cfg_t;

    typedef struct packed {
        logic [SEL_W-1:0]    prg_sel;
        logic [SEL_W-1:0]    chr_lo;
        logic [SEL_W-1:0]    chr_hi;
        logic                char_4k;
        logic [PMODE_W-1:0]  prog_mode;
        logic [MIRROR_W-1:0] mirror;
        logic                never_banked;
    } bank_state_t;

    // Program bank count clamped to 1..MAX_PRG_BANKS
    function automatic logic [PRG_CNT_W-1:0] prg_count_clamp(input logic [PRG_CNT_W-1:0] c);
        logic [PRG_CNT_W-1:0] r;
        r = c;
        if (c == '0) begin
            r = PRG_CNT_W'(1);
        end else if (c > PRG_CNT_W'(MAX_PRG_BANKS)) begin
            r = PRG_CNT_W'(MAX_PRG_BANKS);
        end
        return r;
    endfunction

    // Next power of two of n, minus one; zero for n == 0
    function automatic logic [6:0] pow2_mask(input logic [6:0] n);
        logic [6:0] m;
        m = n - 7'd1;
        m = m | (m >> 1);
        m = m | (m >> 2);
        m = m | (m >> 4);
        if (n == '0) begin
            m = '0;
        end
        return m;
    endfunction

endpackage

// ===== rtl/core/cbm_xlate.sv =====
// Read address translation: program and character windows to ROM offsets.
// Depends on cbm_pkg.
module cbm_xlate (
    input  logic [cbm_pkg::OP_W-1:0]     op,
    input  logic [cbm_pkg::ADDR_W-1:0]   address,
    input  cbm_pkg::bank_state_t         bank,
    input  cbm_pkg::cfg_t                cfg,
    output logic [cbm_pkg::OFFSET_W-1:0] rom_offset
);

    logic [cbm_pkg::PRG_CNT_W-1:0] count;
    logic [cbm_pkg::SEL_W-1:0]     last_bank;
    logic                          prg_upper;
    logic                          chr_upper;
    logic [cbm_pkg::SEL_W-1:0]     prg_bank;
    logic [cbm_pkg::SEL_W-1:0]     chr_bank;
    logic [cbm_pkg::OFFSET_W-1:0]  prg_off;
    logic [cbm_pkg::OFFSET_W-1:0]  chr_off;

    assign count     = cbm_pkg::prg_count_clamp(cfg.prg_count);
    assign last_bank = cbm_pkg::SEL_W'(count - cbm_pkg::PRG_CNT_W'(1));
    assign prg_upper = address[15] & address[14];   // >= 0xC000
    assign chr_upper = address[15:12] != 4'd0;      // >= 0x1000

    always_comb begin
        if (bank.never_banked) begin
            prg_bank = prg_upper ? last_bank : '0;
        end else if (bank.prog_mode < cbm_pkg::PMODE_SWAP) begin
            prg_bank = {bank.prg_sel[4:1], prg_upper};
        end else if (bank.prog_mode == cbm_pkg::PMODE_SWAP) begin
            prg_bank = prg_upper ? bank.prg_sel : {bank.prg_sel[4], 4'd0};
        end else if (!prg_upper) begin
            prg_bank = bank.prg_sel;
        end else if (count > cbm_pkg::PRG_CNT_W'(16)) begin
            prg_bank = {bank.prg_sel[4], 4'hF};
        end else begin
            prg_bank = last_bank;
        end
    end

    always_comb begin
        if (bank.char_4k) begin
            chr_bank = chr_upper ? bank.chr_hi : bank.chr_lo;
        end else begin
            chr_bank = {bank.chr_lo[4:1], chr_upper};
        end
    end

    assign prg_off = {prg_bank, address[13:0]};

    always_comb begin
        if (cfg.chr_is_ram) begin
            chr_off = cbm_pkg::OFFSET_W'(address[12:0]);
        end else begin
            chr_off = cbm_pkg::OFFSET_W'({chr_bank, address[11:0]});
        end
    end

    always_comb begin
        case (cbm_pkg::op_t'(op))
            cbm_pkg::OP_PRG_READ: rom_offset = prg_off;
            cbm_pkg::OP_CHR_READ: rom_offset = chr_off;
            default:              rom_offset = '0;
        endcase
    end

endmodule

// ===== rtl/core/cartridge_bank_mapper_serial_load_core.sv =====
// Top level of the serial-load cartridge bank mapper core.
// Depends on cbm_pkg and cbm_xlate.
//
// One word in, one word out, at up to one word per clock. An accepted word
// lands in an input register; once the result register is free or being
// drained, a single pass of logic applies it to the mapper state (shift
// register, bank and mode registers) and loads the result register, so
// m_tvalid follows the input and result registers (two register stages) and
// the sustained rate is one word per cycle while m_tready is high. The input
// register keeps taking words while a result waits on m_tready; only when
// both registers are full does s_tready drop. Reads (operation 0 program,
// 1 character) return the translated ROM byte offset; writes (operation 2)
// feed the five-write serial loader, and register_committed flags the fifth
// write. Mirroring in every result is the mode after that word took effect.
// Configuration writes on cfg_* take effect at once and are meant for idle
// periods.
module cartridge_bank_mapper_serial_load_core (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_tvalid,
    output logic                           s_tready,
    // operation[1:0], address[17:2], value[25:18], write_cyc[57:26], zero pad
    input  logic [cbm_pkg::S_TDATA_W-1:0]  s_tdata,

    output logic                           m_tvalid,
    input  logic                           m_tready,
    // rom_offset[18:0], mirroring[20:19], register_committed[21], zero pad
    output logic [cbm_pkg::M_TDATA_W-1:0]  m_tdata,

    input  logic                           cfg_wr_en,
    input  logic [cbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cbm_pkg::CFG_DAT_W-1:0]  cfg_wdata
);

    // configuration
    cbm_pkg::cfg_t cfg_reg;

    // input stage
    logic                          in_valid_reg;
    logic [cbm_pkg::OP_W-1:0]      in_op_reg;
    logic [cbm_pkg::ADDR_W-1:0]    in_addr_reg;
    logic [cbm_pkg::VALUE_W-1:0]   in_value_reg;
    logic [cbm_pkg::CYCLE_W-1:0]   in_cycle_reg;

    // mapper state
    cbm_pkg::bank_state_t          bank_reg, bank_next;
    logic [cbm_pkg::SHIFT_W-1:0]   shift_reg, shift_next;
    logic [cbm_pkg::CYCLE_W-1:0]   last_cycle_reg;
    logic                          last_cycle_vld_reg;

    // result stage
    logic                          out_valid_reg;
    logic [cbm_pkg::OFFSET_W-1:0]  out_offset_reg;
    logic [cbm_pkg::MIRROR_W-1:0]  out_mirror_reg;
    logic                          out_commit_reg;

    logic                          adv;
    logic                          is_write;
    logic                          dup_write;
    logic                          commit_c;
    logic [cbm_pkg::SHIFT_W-1:0]   shifted;
    logic [cbm_pkg::SEL_W-1:0]     load_data;
    logic [6:0]                    prg_msk_full;
    logic [6:0]                    chr_msk_full;
    logic [cbm_pkg::SEL_W-1:0]     prg_msk;
    logic [cbm_pkg::SEL_W-1:0]     chr_msk;
    logic [cbm_pkg::OFFSET_W-1:0]  offset_c;

    // ---------------- handshake ----------------
    assign adv      = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = cbm_pkg::M_TDATA_W'({out_commit_reg, out_mirror_reg, out_offset_reg});

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prg_count  <= cbm_pkg::PRG_CNT_RST;
            cfg_reg.chr_count  <= cbm_pkg::CHR_CNT_RST;
            cfg_reg.chr_is_ram <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cbm_pkg::cfg_idx_t'(cfg_index))
                cbm_pkg::CFG_PRG_COUNT: cfg_reg.prg_count  <= cfg_wdata;
                cbm_pkg::CFG_CHR_COUNT: cfg_reg.chr_count  <= cfg_wdata[cbm_pkg::CHR_CNT_W-1:0];
                cbm_pkg::CFG_CHR_RAM:   cfg_reg.chr_is_ram <= cfg_wdata[0];
                default: ;  // unmapped index, ignored
            endcase
        end
    end

    // ---------------- input register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg    <= s_tdata[1:0];
            in_addr_reg  <= s_tdata[17:2];
            in_value_reg <= s_tdata[25:18];
            in_cycle_reg <= s_tdata[57:26];
        end
    end

    // ---------------- read translation ----------------
    cbm_xlate u_xlate (
        .op         (in_op_reg),
        .address    (in_addr_reg),
        .bank       (bank_reg),
        .cfg        (cfg_reg),
        .rom_offset (offset_c)
    );

    // ---------------- serial loader ----------------
    // bank selects are masked to the next power of two of the banks present
    assign prg_msk_full = cbm_pkg::pow2_mask(7'(cbm_pkg::prg_count_clamp(cfg_reg.prg_count)));
    assign chr_msk_full = cbm_pkg::pow2_mask({1'b0, cfg_reg.chr_count, 1'b0});
    assign prg_msk      = prg_msk_full[cbm_pkg::SEL_W-1:0];
    assign chr_msk      = chr_msk_full[cbm_pkg::SEL_W-1:0];

    assign is_write   = cbm_pkg::op_t'(in_op_reg) == cbm_pkg::OP_REG_WRITE;
    assign dup_write  = last_cycle_vld_reg && (in_cycle_reg == last_cycle_reg);
    assign shifted    = {in_value_reg[0], shift_reg[cbm_pkg::SHIFT_W-1:1]};
    assign load_data  = shifted[cbm_pkg::SHIFT_W-1:1];

    always_comb begin
        bank_next  = bank_reg;
        shift_next = shift_reg;
        commit_c   = 1'b0;
        if (is_write) begin
            if (in_value_reg[7]) begin
                // reset write: clear loader, fix last bank high
                shift_next            = cbm_pkg::SHIFT_INIT;
                bank_next.prog_mode   = cbm_pkg::PMODE_FIX_HI;
                bank_next.never_banked = 1'b0;
            end else if (!dup_write) begin
                if (!shifted[0]) begin
                    shift_next = shifted;
                end else begin
                    // marker reached bit 0: fifth bit in, commit
                    shift_next = cbm_pkg::SHIFT_INIT;
                    commit_c   = 1'b1;
                    case (cbm_pkg::tgt_t'(in_addr_reg[15:13]))
                        cbm_pkg::TGT_CONTROL: begin
                            bank_next.mirror       = load_data[1:0];
                            bank_next.prog_mode    = load_data[3:2];
                            bank_next.char_4k      = load_data[4];
                            bank_next.never_banked = 1'b0;
                        end
                        cbm_pkg::TGT_CHR0: begin
                            if (cfg_reg.chr_is_ram) begin
                                bank_next.prg_sel      = {load_data[4], bank_reg.prg_sel[3:0]}
                                                         & prg_msk;
                                bank_next.never_banked = 1'b0;
                            end else begin
                                bank_next.chr_lo = load_data & chr_msk;
                            end
                        end
                        cbm_pkg::TGT_CHR1: begin
                            // dropped while in 8 KB character mode
                            if (bank_reg.char_4k) begin
                                if (cfg_reg.chr_is_ram) begin
                                    bank_next.prg_sel      = {load_data[4],
                                                              bank_reg.prg_sel[3:0]} & prg_msk;
                                    bank_next.never_banked = 1'b0;
                                end else begin
                                    bank_next.chr_hi = load_data & chr_msk;
                                end
                            end
                        end
                        cbm_pkg::TGT_PRG: begin
                            bank_next.prg_sel      = {bank_reg.prg_sel[4], load_data[3:0]}
                                                     & prg_msk;
                            bank_next.never_banked = 1'b0;
                        end
                        default: ;  // below 0x8000: load discarded, still committed
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg             <= cbm_pkg::SHIFT_INIT;
            bank_reg.prg_sel      <= '0;
            bank_reg.chr_lo       <= '0;
            bank_reg.chr_hi       <= '0;
            bank_reg.char_4k      <= 1'b0;
            bank_reg.prog_mode    <= cbm_pkg::PMODE_FIX_HI;
            bank_reg.mirror       <= '0;
            bank_reg.never_banked <= 1'b1;
            last_cycle_vld_reg    <= 1'b0;
            last_cycle_reg        <= '1;
        end else if (adv) begin
            shift_reg <= shift_next;
            bank_reg  <= bank_next;
            if (is_write) begin
                last_cycle_reg     <= in_cycle_reg;
                last_cycle_vld_reg <= 1'b1;
            end
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_offset_reg <= offset_c;
            out_mirror_reg <= bank_next.mirror;
            out_commit_reg <= commit_c;
        end
    end

    // ---------------- assertions ----------------
    a_marker_present: assert property (@(posedge aclk) disable iff (!aresetn)
        shift_reg != '0)
        else $error("loader shift register lost its marker bit");

    a_commit_reloads: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && commit_c |=> shift_reg == cbm_pkg::SHIFT_INIT)
        else $error("shift register not reloaded after a commit");

    a_commit_only_write: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && !is_write |-> !commit_c && bank_next == bank_reg)
        else $error("read word changed mapper state");

    a_banked_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        !bank_reg.never_banked |=> !bank_reg.never_banked)
        else $error("never_banked set again after banking");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !adv |=> in_valid_reg && $stable(in_op_reg))
        else $error("pending input word lost");

endmodule
